### hw/rtl/lenr_pkg.sv
package lenr_pkg;

  localparam int MAX_ORDER      = 64;
  localparam int MAX_ITERATIONS = 64;

  localparam int K_W     = $clog2(MAX_ORDER + 2);
  localparam int ITER_W  = ($clog2(MAX_ITERATIONS + 1) > 7) ? $clog2(MAX_ITERATIONS + 1) : 7;
  localparam int NUM_W   = 64;
  localparam int CNT_W   = 6;
  localparam int MUL_PARTS = 4;
  localparam int DIV_STEPS = NUM_W / 8;
  localparam int ND_BITS   = 34;

  localparam logic signed [47:0] Q32_ONE = 48'sh0001_0000_0000;
  localparam logic signed [NUM_W-1:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [NUM_W-1:0] S48_MIN = -64'sh0000_8000_0000_0000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EVI,
    OP_MUL,
    OP_COMB,
    OP_LIN1,
    OP_LIN2,
    OP_DIV,
    OP_UPD,
    OP_NDI,
    OP_NDR,
    OP_NUP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_SLOPE = 2'd1,
    ST_ITER_LIMIT = 2'd2
  } code_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
    code_t      code;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic ev_done;
    logic slope_zero;
    logic iter_limit;
    logic converged;
  } stat_t;

  function automatic logic signed [47:0] sat48(input logic signed [NUM_W-1:0] v);
    logic signed [47:0] r;
    if (v > S48_MAX) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < S48_MIN) begin
      r = -48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/lenr_ctrl.sv
module lenr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lenr_pkg::stat_t  stat,
  output lenr_pkg::cmd_t   cmd,
  output logic             busy
);

  localparam int CNT_W = lenr_pkg::CNT_W;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_EVI  = 14'b00000000000010,
    S_EVT  = 14'b00000000000100,
    S_MUL  = 14'b00000000001000,
    S_COMB = 14'b00000000010000,
    S_LIN1 = 14'b00000000100000,
    S_LIN2 = 14'b00000001000000,
    S_DIV  = 14'b00000010000000,
    S_UPD  = 14'b00000100000000,
    S_AFT  = 14'b00001000000000,
    S_NDI  = 14'b00010000000000,
    S_NDR  = 14'b00100000000000,
    S_NUP  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t                      state, state_next;
  logic [lenr_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic                        after_step, after_step_next;
  lenr_pkg::code_t             code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      after_step <= 1'b0;
      code       <= lenr_pkg::ST_OK;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      after_step <= after_step_next;
      code       <= code_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    after_step_next = after_step;
    code_next       = code;
    cmd.op          = lenr_pkg::OP_NOP;
    cmd.sel         = cnt[1:0];
    cmd.code        = code;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op          = lenr_pkg::OP_LOAD;
          after_step_next = 1'b0;
          state_next      = S_EVI;
        end
      end
      S_EVI: begin
        cmd.op     = lenr_pkg::OP_EVI;
        state_next = S_EVT;
      end
      S_EVT: begin
        cnt_next   = '0;
        state_next = stat.ev_done ? S_AFT : S_MUL;
      end
      S_MUL: begin
        cmd.op = lenr_pkg::OP_MUL;
        if (cnt == CNT_W'(lenr_pkg::MUL_PARTS - 1)) begin
          cnt_next   = '0;
          state_next = S_COMB;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_COMB: begin
        cmd.op     = lenr_pkg::OP_COMB;
        state_next = S_LIN1;
      end
      S_LIN1: begin
        cmd.op     = lenr_pkg::OP_LIN1;
        state_next = S_LIN2;
      end
      S_LIN2: begin
        cmd.op     = lenr_pkg::OP_LIN2;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = lenr_pkg::OP_DIV;
        if (cnt == CNT_W'(lenr_pkg::DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = S_UPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_UPD: begin
        cmd.op     = lenr_pkg::OP_UPD;
        state_next = S_EVT;
      end
      S_AFT: begin
        priority if (!stat.mode || (after_step && stat.converged)) begin
          code_next  = lenr_pkg::ST_OK;
          state_next = S_DONE;
        end else if (stat.slope_zero) begin
          code_next  = lenr_pkg::ST_ZERO_SLOPE;
          state_next = S_DONE;
        end else if (stat.iter_limit) begin
          code_next  = lenr_pkg::ST_ITER_LIMIT;
          state_next = S_DONE;
        end else begin
          state_next = S_NDI;
        end
      end
      S_NDI: begin
        cmd.op     = lenr_pkg::OP_NDI;
        cnt_next   = '0;
        state_next = S_NDR;
      end
      S_NDR: begin
        cmd.op = lenr_pkg::OP_NDR;
        if (cnt == CNT_W'(lenr_pkg::ND_BITS - 1)) begin
          cnt_next   = '0;
          state_next = S_NUP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_NUP: begin
        cmd.op          = lenr_pkg::OP_NUP;
        after_step_next = 1'b1;
        state_next      = S_EVI;
      end
      S_DONE: begin
        cmd.op     = lenr_pkg::OP_EMIT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/lenr_dpath.sv
module lenr_dpath (
  input  logic                clk,
  input  logic                rst,
  input  lenr_pkg::cmd_t      cmd,
  output lenr_pkg::stat_t     stat,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic                mode_in,
  input  logic signed [31:0]  point_in,
  output logic                done,
  output logic signed [47:0]  poly_value,
  output logic signed [47:0]  poly_slope,
  output logic signed [31:0]  root,
  output logic [1:0]          status,
  output logic [6:0]          iterations
);

  localparam int K_W    = lenr_pkg::K_W;
  localparam int NUM_W  = lenr_pkg::NUM_W;
  localparam int ITER_W = lenr_pkg::ITER_W;

  logic [6:0]                      poly_order;
  logic [30:0]                     tolerance;
  logic                            mode;
  logic signed [31:0]              x;
  logic [K_W-1:0]                  ord;
  logic [K_W-1:0]                  k;
  logic signed [47:0]              p1, p2, d1, d2;
  logic [55:0]                     pa, pb, da, db;
  logic signed [50:0]              mxp, mxd;
  logic signed [NUM_W-1:0]         tp, td, up, ud;
  logic [NUM_W-1:0]                dvd_p, dvd_d, q_p, q_d;
  logic [K_W-1:0]                  rem_p, rem_d;
  logic                            neg_p, neg_d;
  logic [48:0]                     nd_r;
  logic [33:0]                     nd_bits, nd_q;
  logic                            nd_sat;
  logic                            conv;
  logic [ITER_W-1:0]               iters;

  logic [31:0]                     xm;
  logic [47:0]                     p1m, d1m;
  logic [23:0]                     mop;
  logic [55:0]                     mprod;
  logic [79:0]                     sum_p, sum_d;
  logic [49:0]                     rp, rd;
  logic [K_W:0]                    c1;
  logic [K_W-1:0]                  c2;
  logic signed [K_W+1:0]           c1s;
  logic signed [K_W:0]             c2s;
  logic signed [51:0]              pd_sum;
  logic signed [NUM_W-1:0]         nump, numd;
  logic [NUM_W-1:0]                magp, magd, half_k;
  logic [K_W+7:0]                  dv_p, dv_d;
  logic signed [NUM_W-1:0]         qps, qds;
  logic [49:0]                     nd_t;
  logic                            nd_ge;
  logic [34:0]                     nd_inc;
  logic [33:0]                     step_m;
  logic signed [34:0]              step;
  logic signed [35:0]              nx_w;
  logic signed [31:0]              nx;
  logic signed [32:0]              dif;
  logic [32:0]                     dif_m;
  logic [31:0]                     po32;

  function automatic logic [K_W+7:0] div8(input logic [K_W-1:0] r_in,
                                          input logic [7:0] bits,
                                          input logic [K_W-1:0] kd);
    logic [K_W-1:0] r;
    logic [K_W:0]   t;
    logic [7:0]     q;
    r = r_in;
    q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, kd}) begin
        r    = K_W'(t - {1'b0, kd});
        q[i] = 1'b1;
      end else begin
        r = t[K_W-1:0];
      end
    end
    return {r, q};
  endfunction

  assign xm  = x[31]  ? 32'(~x + 32'sd1)  : 32'(x);
  assign p1m = p1[47] ? 48'(~p1 + 48'sd1) : 48'(p1);
  assign d1m = d1[47] ? 48'(~d1 + 48'sd1) : 48'(d1);

  always_comb begin
    unique case (cmd.sel)
      2'd0:    mop = p1m[47:24];
      2'd1:    mop = p1m[23:0];
      2'd2:    mop = d1m[47:24];
      default: mop = d1m[23:0];
    endcase
  end
  assign mprod = 56'(xm) * 56'(mop);

  assign sum_p = {pa, 24'b0} + 80'(pb) + 80'(32'h2000_0000);
  assign sum_d = {da, 24'b0} + 80'(db) + 80'(32'h2000_0000);
  assign rp    = sum_p[79:30];
  assign rd    = sum_d[79:30];

  assign c1     = {k, 1'b0} - (K_W+1)'(1);
  assign c2     = k - K_W'(1);
  assign c1s    = $signed({1'b0, c1});
  assign c2s    = $signed({1'b0, c2});
  assign pd_sum = 52'(p1) + 52'(mxd);

  assign nump   = tp - up;
  assign numd   = td - ud;
  assign magp   = nump[NUM_W-1] ? NUM_W'(~nump + NUM_W'(1)) : NUM_W'(nump);
  assign magd   = numd[NUM_W-1] ? NUM_W'(~numd + NUM_W'(1)) : NUM_W'(numd);
  assign half_k = NUM_W'(k >> 1);

  assign dv_p = div8(rem_p, dvd_p[NUM_W-1 -: 8], k);
  assign dv_d = div8(rem_d, dvd_d[NUM_W-1 -: 8], k);
  assign qps  = $signed(q_p);
  assign qds  = $signed(q_d);

  assign nd_t   = {nd_r, nd_bits[33]};
  assign nd_ge  = (nd_t >= 50'(d1m));
  assign nd_inc = {1'b0, nd_q} + 35'd1;
  assign step_m = nd_sat ? 34'h2_0000_0000 : nd_inc[34:1];
  assign step   = (p1[47] ^ d1[47]) ? -$signed({1'b0, step_m}) : $signed({1'b0, step_m});
  assign nx_w   = 36'(x) - 36'(step);
  assign nx     = lenr_pkg::sat32(nx_w);
  assign dif    = 33'(nx) - 33'(x);
  assign dif_m  = dif[32] ? 33'(~dif + 33'sd1) : 33'(dif);

  assign po32 = 32'(poly_order);

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_order <= 7'd2;
      tolerance  <= 31'd1024;
    end else if (cfg_we) begin
      if (cfg_index) begin
        tolerance <= cfg_data;
      end else begin
        poly_order <= cfg_data[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == lenr_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      lenr_pkg::OP_LOAD: begin
        mode  <= mode_in;
        x     <= point_in;
        iters <= '0;
        conv  <= 1'b0;
        ord   <= (po32 > 32'(lenr_pkg::MAX_ORDER)) ? K_W'(lenr_pkg::MAX_ORDER) : K_W'(po32);
      end
      lenr_pkg::OP_EVI: begin
        p2 <= lenr_pkg::Q32_ONE;
        d2 <= '0;
        k  <= K_W'(2);
        if (ord == '0) begin
          p1 <= lenr_pkg::Q32_ONE;
          d1 <= '0;
        end else begin
          p1 <= {{14{x[31]}}, x, 2'b00};
          d1 <= lenr_pkg::Q32_ONE;
        end
      end
      lenr_pkg::OP_MUL: begin
        unique case (cmd.sel)
          2'd0:    pa <= mprod;
          2'd1:    pb <= mprod;
          2'd2:    da <= mprod;
          default: db <= mprod;
        endcase
      end
      lenr_pkg::OP_COMB: begin
        mxp <= (x[31] ^ p1[47]) ? -$signed({1'b0, rp}) : $signed({1'b0, rp});
        mxd <= (x[31] ^ d1[47]) ? -$signed({1'b0, rd}) : $signed({1'b0, rd});
      end
      lenr_pkg::OP_LIN1: begin
        tp <= NUM_W'(mxp) * NUM_W'(c1s);
        td <= NUM_W'(pd_sum) * NUM_W'(c1s);
        up <= NUM_W'(p2) * NUM_W'(c2s);
        ud <= NUM_W'(d2) * NUM_W'(c2s);
      end
      lenr_pkg::OP_LIN2: begin
        neg_p <= nump[NUM_W-1];
        neg_d <= numd[NUM_W-1];
        dvd_p <= magp + half_k;
        dvd_d <= magd + half_k;
        rem_p <= '0;
        rem_d <= '0;
        q_p   <= '0;
        q_d   <= '0;
      end
      lenr_pkg::OP_DIV: begin
        dvd_p <= dvd_p << 8;
        dvd_d <= dvd_d << 8;
        rem_p <= dv_p[K_W+7:8];
        rem_d <= dv_d[K_W+7:8];
        q_p   <= {q_p[NUM_W-9:0], dv_p[7:0]};
        q_d   <= {q_d[NUM_W-9:0], dv_d[7:0]};
      end
      lenr_pkg::OP_UPD: begin
        p2 <= p1;
        d2 <= d1;
        p1 <= lenr_pkg::sat48(neg_p ? -qps : qps);
        d1 <= lenr_pkg::sat48(neg_d ? -qds : qds);
        k  <= k + K_W'(1);
      end
      lenr_pkg::OP_NDI: begin
        nd_sat  <= ({3'b0, p1m} >= {d1m, 3'b0});
        nd_r    <= 49'(p1m >> 3);
        nd_bits <= {p1m[2:0], 31'b0};
        nd_q    <= '0;
      end
      lenr_pkg::OP_NDR: begin
        nd_r    <= nd_ge ? 49'(nd_t - 50'(d1m)) : nd_t[48:0];
        nd_q    <= {nd_q[32:0], nd_ge};
        nd_bits <= nd_bits << 1;
      end
      lenr_pkg::OP_NUP: begin
        x     <= nx;
        conv  <= (dif_m < 33'(tolerance));
        iters <= iters + 1'b1;
      end
      lenr_pkg::OP_EMIT: begin
        poly_value <= p1;
        poly_slope <= d1;
        root       <= x;
        status     <= cmd.code;
        iterations <= iters[6:0];
      end
      default: begin
      end
    endcase
  end

  assign stat.mode       = mode;
  assign stat.ev_done    = (k > ord);
  assign stat.slope_zero = (d1 == '0);
  assign stat.iter_limit = (iters >= ITER_W'(lenr_pkg::MAX_ITERATIONS));
  assign stat.converged  = conv;

endmodule

### hw/rtl/legendre_eval_newton_root.sv
// Each recurrence step is 4 multiplier passes, a combine step, the LIN1 and LIN2
// steps, radix-256 divide steps and an update. Mode 1 adds per Newton step a
// serial P/P' division plus one full evaluation; up to 64 steps. One request at a
// time: start is taken only while busy is low; done is a one-cycle strobe the
// receiver cannot stall.
// Reset (synchronous, rst high) returns to idle, poly_order = 2, tolerance = 1024.
module legendre_eval_newton_root (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                mode,
  input  logic signed [31:0]  point,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [30:0]         cfg_data,
  output logic                done,
  output logic signed [47:0]  poly_value,
  output logic signed [47:0]  poly_slope,
  output logic signed [31:0]  root,
  output logic [1:0]          status,
  output logic [6:0]          iterations
);

  lenr_pkg::cmd_t  cmd;
  lenr_pkg::stat_t stat;

  lenr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lenr_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode_in    (mode),
    .point_in   (point),
    .done       (done),
    .poly_value (poly_value),
    .poly_slope (poly_slope),
    .root       (root),
    .status     (status),
    .iterations (iterations)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_take_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_strobe_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    done && status == lenr_pkg::ST_ITER_LIMIT |-> iterations == 7'(lenr_pkg::MAX_ITERATIONS))
    else $error("iteration limit reported with wrong count");

endmodule

### verif/lenr_checker.sv
module lenr_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               mode,
  input  logic signed [31:0] point,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               done,
  input  logic signed [47:0] poly_value,
  input  logic signed [47:0] poly_slope,
  input  logic signed [31:0] root,
  input  logic [1:0]         status,
  input  logic [6:0]         iterations,
  output int                 fail_count,
  output int                 pending
);

  localparam int CFG_ORDER = 0;
  localparam int CFG_TOL   = 1;
  localparam longint Q1 = 64'sd1 <<< 32;
  localparam longint SMAX = (64'sd1 <<< 47) - 1;
  localparam longint SMIN = -(64'sd1 <<< 47);

  typedef struct {
    logic signed [47:0] value;
    logic signed [47:0] slope;
    logic signed [31:0] est;
    lenr_pkg::code_t    code;
    logic [6:0]         steps;
  } legendre_res_t;

  logic [6:0]  order_reg;
  logic [30:0] tol_reg;
  legendre_res_t expected_q[$];

  function automatic longint clip48(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint scale_by_x(longint x, longint v);
    longint unsigned xm, vm, hi, lo, a, b, r;
    xm = absval(x);
    vm = absval(v);
    hi = vm >> 24;
    lo = vm & 64'hFFFFFF;
    a = xm * hi;
    b = xm * lo;
    r = (a >> 6) + ((((a & 63) << 24) + b + (64'd1 << 29)) >> 30);
    return ((x < 0) != (v < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint div_round(longint num, longint k);
    longint unsigned m, q;
    m = absval(num);
    q = (m + k / 2) / k;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic eval_legendre(input longint x, input int ord, output longint val,
                               output longint slope);
    longint p2, p1, d2, d1, pn, dn, c1, c2;
    p2 = Q1;
    p1 = x * 4;
    d2 = 0;
    d1 = Q1;
    if (ord == 0) begin
      val = Q1;
      slope = 0;
      return;
    end
    for (int k = 2; k <= ord; k++) begin
      c1 = 2 * k - 1;
      c2 = k - 1;
      pn = clip48(div_round(c1 * scale_by_x(x, p1) - c2 * p2, k));
      dn = clip48(div_round(c1 * (p1 + scale_by_x(x, d1)) - c2 * d2, k));
      p2 = p1;
      p1 = pn;
      d2 = d1;
      d1 = dn;
    end
    val = p1;
    slope = d1;
  endtask

  function automatic longint newton_delta(longint p, longint d);
    longint unsigned pm, dm, q0, r, frac, m;
    pm = absval(p);
    dm = absval(d);
    q0 = pm / dm;
    frac = 0;
    if (q0 >= 8) begin
      m = 64'd1 << 33;
    end else begin
      r = pm - q0 * dm;
      for (int i = 0; i < 31; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= dm) begin
          r = r - dm;
          frac = frac | 1;
        end
      end
      m = (((q0 << 31) | frac) + 1) >> 1;
    end
    return ((p < 0) != (d < 0)) ? -longint'(m) : longint'(m);
  endfunction

  task automatic predict_request(input logic md, input logic signed [31:0] pt);
    legendre_res_t e;
    longint x, nx, val, slope;
    longint unsigned dif;
    int ord, steps;
    lenr_pkg::code_t code;
    ord = order_reg > lenr_pkg::MAX_ORDER ? lenr_pkg::MAX_ORDER : order_reg;
    x = pt;
    steps = 0;
    code = lenr_pkg::ST_OK;
    eval_legendre(x, ord, val, slope);
    if (md) begin
      forever begin
        if (slope == 0) begin
          code = lenr_pkg::ST_ZERO_SLOPE;
          break;
        end
        if (steps >= lenr_pkg::MAX_ITERATIONS) begin
          code = lenr_pkg::ST_ITER_LIMIT;
          break;
        end
        nx = x - newton_delta(val, slope);
        if (nx > 64'sd2147483647) nx = 64'sd2147483647;
        if (nx < -64'sd2147483648) nx = -64'sd2147483648;
        dif = absval(nx - x);
        steps++;
        x = nx;
        eval_legendre(x, ord, val, slope);
        if (dif < tol_reg) begin
          code = lenr_pkg::ST_OK;
          break;
        end
      end
    end
    e.value = val[47:0];
    e.slope = slope[47:0];
    e.est = x[31:0];
    e.code = code;
    e.steps = steps[6:0];
    expected_q.push_back(e);
  endtask

  always @(posedge clk) begin
    legendre_res_t e;
    int errs;
    errs = 0;
    if (rst) begin
      order_reg <= 7'd2;
      tol_reg <= 31'd1024;
      fail_count <= 0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ORDER) order_reg <= cfg_data[6:0];
        if (cfg_index == CFG_TOL) tol_reg <= cfg_data;
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (poly_value !== e.value) begin
            $error("poly_value exp %0d got %0d", e.value, poly_value);
            errs++;
          end
          if (poly_slope !== e.slope) begin
            $error("poly_slope exp %0d got %0d", e.slope, poly_slope);
            errs++;
          end
          if (root !== e.est) begin
            $error("root exp %0d got %0d", e.est, root);
            errs++;
          end
          if (status !== e.code) begin
            $error("status exp %0d got %0d", e.code, status);
            errs++;
          end
          if (iterations !== e.steps) begin
            $error("iterations exp %0d got %0d", e.steps, iterations);
            errs++;
          end
        end
      end
      if (start && !busy) predict_request(mode, point);
      fail_count <= fail_count + errs;
      pending <= expected_q.size();
    end
  end
endmodule

### verif/tb_legendre_eval_newton_root.sv
module tb_legendre_eval_newton_root;

  localparam logic CFG_ORDER = 1'b0;
  localparam logic CFG_TOL   = 1'b1;
  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_ROOT = 1'b1;
  localparam longint CYCLE_LIMIT = 64'd200_000_000;

  logic clk, rst, start, busy, mode, cfg_we, cfg_index, done;
  logic signed [31:0] point, root;
  logic [30:0] cfg_data;
  logic signed [47:0] poly_value, poly_slope;
  logic [1:0] status;
  logic [6:0] iterations;
  int fail_count, pending;
  longint cycles;

  legendre_eval_newton_root dut (.*);
  lenr_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("legendre_eval_newton_root test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_request(input logic md, input logic signed [31:0] pt);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    mode <= md;
    point <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_point();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      default: return $signed($urandom_range(0, 32'h7FFF_FFFE)) - 32'sh3FFF_FFFF;
    endcase
  endfunction

  function automatic logic [6:0] rand_order();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 7'($urandom_range(65, 127));
    if (r == 1) return 7'($urandom_range(30, 64));
    return 7'($urandom_range(0, 8));
  endfunction

  function automatic logic [30:0] rand_tol();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(1, 32'h4000_0000));
      1: return 31'($urandom_range(1, 16));
      default: return 31'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  initial begin
    logic signed [31:0] edge_pts[6];
    cycles = 0;
    rst = 1;
    start = 0;
    mode = 0;
    point = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    edge_pts = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh4000_0000, -32'sh4000_0000,
                 32'sh2000_0000};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (edge_pts[i]) send_request(MODE_EVAL, edge_pts[i]);
    send_request(MODE_ROOT, 32'sh2000_0000);
    send_request(MODE_ROOT, 0);
    drain();
    write_reg(CFG_ORDER, 31'd0);
    send_request(MODE_EVAL, 32'sh1234_5678);
    send_request(MODE_ROOT, 32'sh1234_5678);
    drain();
    write_reg(CFG_ORDER, 31'd64);
    write_reg(CFG_TOL, 31'h4000_0000);
    send_request(MODE_EVAL, 32'sh7FFF_FFFF);
    send_request(MODE_ROOT, 32'sh3000_0000);
    drain();
    write_reg(CFG_ORDER, 31'd127);
    write_reg(CFG_TOL, 31'd1);
    send_request(MODE_EVAL, -32'sh3000_0000);
    send_request(MODE_ROOT, 32'sh1000_0000);
    drain();
    write_reg(CFG_ORDER, 31'd3);
    write_reg(CFG_TOL, 31'h7FFF_FFFF);
    send_request(MODE_ROOT, 32'sh7FFF_FFFF);
    drain();
    write_reg(CFG_ORDER, 31'd1);
    write_reg(CFG_TOL, 31'd1);
    send_request(MODE_ROOT, 32'sh8000_0000);
    send_request(MODE_EVAL, 32'sh5555_5555);

    for (int ph = 0; ph < 20; ph++) begin
      drain();
      write_reg(CFG_ORDER, 31'(rand_order()));
      write_reg(CFG_TOL, rand_tol());
      for (int i = 0; i < 29; i++) send_request(1'($urandom), rand_point());
    end

    drain();
    if (fail_count == 0) begin
      $display("legendre_eval_newton_root test passed");
    end else begin
      $display("legendre_eval_newton_root test failed");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/lenr_pkg.sv
hw/rtl/lenr_ctrl.sv
hw/rtl/lenr_dpath.sv
hw/rtl/legendre_eval_newton_root.sv
verif/lenr_checker.sv
verif/tb_legendre_eval_newton_root.sv
